FILE: design/key_debounce_edge_hold_timer_macros.svh
// ----------------------------------------------------------------------------
// key_debounce_edge_hold_timer_macros
// assertion macros for the key debounce block, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_EDGE_HOLD_TIMER_MACROS_SVH
`define KEY_DEBOUNCE_EDGE_HOLD_TIMER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define KDEHT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define KDEHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KDEHT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define KDEHT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/kdeht_pkg.sv
// ----------------------------------------------------------------------------
// kdeht_pkg
// shared types and constants of the key debounce block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdeht_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EC_NONE    = 2'd0,
        EC_PRESS   = 2'd1,
        EC_RELEASE = 2'd2
    } edge_code_t;

    localparam logic [7:0] HOLD_MAX = 8'd255;

    // command broadcast to every channel
    typedef struct packed {
        logic en;
        logic sample;
        logic tick;
        logic clear;
        logic level;
    } chan_cmd_t;

    // per-channel status after the update
    typedef struct packed {
        logic       pressed;
        edge_code_t edge_code;
        logic [7:0] hold;
    } chan_status_t;

endpackage

FILE: design/kdeht_chan.sv
// ----------------------------------------------------------------------------
// kdeht_chan
// one key channel: sample window, debounced state, edge latch, hold counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdeht_chan #(
    parameter int WINDOW = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kdeht_pkg::chan_cmd_t  cmd,
    input  logic                  sel,
    output kdeht_pkg::chan_status_t status
);
    import kdeht_pkg::*;

    logic [WINDOW-1:0] win_reg,  win_next;
    logic              deb_reg,  deb_next;
    logic              prev_reg, prev_next;
    edge_code_t        ec_reg,   ec_next;
    logic [7:0]        hold_reg, hold_next;

    logic [WINDOW:0]   win_shift;
    logic              changed;
    logic [7:0]        hold_base;

    assign win_shift = {win_reg, cmd.level};
    assign changed   = (prev_reg != deb_reg);
    assign hold_base = changed ? 8'd0 : hold_reg;

    always_comb begin
        win_next  = win_reg;
        deb_next  = deb_reg;
        prev_next = prev_reg;
        ec_next   = ec_reg;
        hold_next = hold_reg;
        if (cmd.en) begin
            if (cmd.sample && sel) begin
                win_next = win_shift[WINDOW-1:0];
                if (&win_shift[WINDOW-1:0]) begin
                    deb_next = 1'b1;
                end else if (~|win_shift[WINDOW-1:0]) begin
                    deb_next = 1'b0;
                end
            end
            if (cmd.tick) begin
                prev_next = deb_reg;
                if (changed) begin
                    ec_next = deb_reg ? EC_PRESS : EC_RELEASE;
                end
                hold_next = (hold_base < HOLD_MAX) ? hold_base + 8'd1 : hold_base;
            end
            if (cmd.clear && sel) begin
                ec_next = EC_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            deb_reg  <= 1'b0;
            prev_reg <= 1'b0;
            ec_reg   <= EC_NONE;
            hold_reg <= '0;
        end else begin
            win_reg  <= win_next;
            deb_reg  <= deb_next;
            prev_reg <= prev_next;
            ec_reg   <= ec_next;
            hold_reg <= hold_next;
        end
    end

    // report the post-update view so the result matches this transaction
    assign status.pressed   = deb_next;
    assign status.edge_code = ec_next;
    assign status.hold      = hold_next;

endmodule

FILE: design/kdeht_out.sv
// ----------------------------------------------------------------------------
// kdeht_out
// result register with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdeht_out (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  kdeht_pkg::chan_status_t data,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic                    m_filtered_state,
    output logic [1:0]              m_edge_code,
    output logic [7:0]              m_hold_time
);
    import kdeht_pkg::*;

    logic         valid_reg;
    chan_status_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data;
        end
    end

    assign m_valid          = valid_reg;
    assign m_filtered_state = data_reg.pressed;
    assign m_edge_code      = data_reg.edge_code;
    assign m_hold_time      = data_reg.hold;

endmodule

FILE: design/key_debounce_edge_hold_timer.sv
// ----------------------------------------------------------------------------
// key_debounce_edge_hold_timer
// multi-channel key debouncer with press/release edge latch and hold timer
// ----------------------------------------------------------------------------
// Takes one transaction per clock whenever the result side is ready and
// returns one result per transaction, in order. A transaction is captured in
// an input register and, once the output register is free or drains, is
// applied to the per-channel state while its result is loaded into the
// output register, which presents it with m_valid. When the result side
// stalls, the input register holds one further transaction and then s_ready
// drops. Operation 0 shifts a sample into the channel window (nonzero raw
// level counts as active), 1 ticks every channel's hold timer and edge latch,
// 2 clears the channel's edge code, 3 only reports. An out-of-range channel
// reports all zeros and changes nothing but what a tick changes.
`timescale 1ns / 1ps

module key_debounce_edge_hold_timer #(
    parameter int CHANNELS = 3,
    parameter int WINDOW   = 5
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input transactions
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [1:0] s_channel,
    input  logic [7:0] s_raw_level,
    // result transactions
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_filtered_state,
    output logic [1:0] m_edge_code,
    output logic [7:0] m_hold_time
);
    import kdeht_pkg::*;

    `include "key_debounce_edge_hold_timer_macros.svh"

    // input register
    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [1:0] ch_reg;
    logic       level_reg;

    logic         advance;
    logic         ch_ok;
    chan_cmd_t    cmd;
    chan_status_t st [CHANNELS];
    chan_status_t result;

    // the input stage moves on whenever the result register is free or drains
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            ch_reg    <= s_channel;
            level_reg <= |s_raw_level;
        end
    end

    assign ch_ok = (32'(ch_reg) < CHANNELS);

    // decoded command, shared by all channels
    assign cmd.en     = advance;
    assign cmd.sample = (op_reg == OP_SAMPLE);
    assign cmd.tick   = (op_reg == OP_TICK);
    assign cmd.clear  = (op_reg == OP_CLEAR);
    assign cmd.level  = level_reg;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
        kdeht_chan #(
            .WINDOW (WINDOW)
        ) u_chan (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .sel     (32'(ch_reg) == i),
            .status  (st[i])
        );
    end

    // pick the reported channel; out of range reports zeros
    always_comb begin
        result = '{pressed: 1'b0, edge_code: EC_NONE, hold: 8'd0};
        for (int i = 0; i < CHANNELS; i++) begin
            if (ch_ok && (32'(ch_reg) == i)) begin
                result = st[i];
            end
        end
    end

    kdeht_out u_out (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (advance),
        .data             (result),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_filtered_state (m_filtered_state),
        .m_edge_code      (m_edge_code),
        .m_hold_time      (m_hold_time)
    );

    // a pending transaction survives a stalled result side
    `KDEHT_ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid_reg && m_valid && !m_ready, in_valid_reg, "pending transaction lost under stall")

    // edge code is one of the defined codes
    `KDEHT_ASSERT_SAME(a_edge_code_legal, aclk, aresetn, m_valid, (m_edge_code == EC_NONE) || (m_edge_code == EC_PRESS) || (m_edge_code == EC_RELEASE), "illegal edge code")

    // a zero hold time means no tick has run, so no edge can be latched
    `KDEHT_ASSERT_SAME(a_hold_zero_no_edge, aclk, aresetn, m_valid && (m_hold_time == 8'd0), m_edge_code == EC_NONE, "edge latched without tick")

endmodule
